// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, ignored while reset is high.
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("assertion failed");

`endif

// ===== src/svga_erf_pkg.sv =====
package svga_erf_pkg;

   typedef enum logic [1:0] {
      FUNC_CRTC_WRITE = 2'd0,
      FUNC_CRTC_READ  = 2'd1,
      FUNC_SEQ_WRITE  = 2'd2,
      FUNC_SEQ_READ   = 2'd3
   } func_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] index;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       mode_changed;
      logic       bank_changed;
      logic       scan_length_changed;
      logic       window_moved;
      logic       timing_changed;
      logic       cursor_mode_changed;
      logic [5:0] bank_value;
      logic [1:0] scan_length_high;
      logic [4:0] display_start_high;
      logic       line_compare_high;
      logic       unknown_index;
   } rsp_type;

   // Extended CRTC register indexes.
   localparam logic [7:0] CR_CHIP_ID_HIGH    = 8'h2d;
   localparam logic [7:0] CR_CHIP_ID_LOW     = 8'h2e;
   localparam logic [7:0] CR_CHIP_REVISION   = 8'h30;
   localparam logic [7:0] CR_MEMORY_CONFIG   = 8'h31;
   localparam logic [7:0] CR_BANK_LOCK       = 8'h35;
   localparam logic [7:0] CR_CONFIG_ONE      = 8'h36;
   localparam logic [7:0] CR_CONFIG_TWO      = 8'h37;
   localparam logic [7:0] CR_UNLOCK_ONE      = 8'h38;
   localparam logic [7:0] CR_UNLOCK_TWO      = 8'h39;
   localparam logic [7:0] CR_SYSTEM_CONFIG   = 8'h40;
   localparam logic [7:0] CR_EXTENDED_MODE   = 8'h43;
   localparam logic [7:0] CR_CURSOR_MODE     = 8'h45;
   localparam logic [7:0] CR_CURSOR_X_HIGH   = 8'h46;
   localparam logic [7:0] CR_CURSOR_X_LOW    = 8'h47;
   localparam logic [7:0] CR_CURSOR_Y_HIGH   = 8'h48;
   localparam logic [7:0] CR_CURSOR_Y_LOW    = 8'h49;
   localparam logic [7:0] CR_FORE_COLOUR     = 8'h4a;
   localparam logic [7:0] CR_BACK_COLOUR     = 8'h4b;
   localparam logic [7:0] CR_CURSOR_ADDR_HI  = 8'h4c;
   localparam logic [7:0] CR_CURSOR_ADDR_LO  = 8'h4d;
   localparam logic [7:0] CR_PATTERN_X       = 8'h4e;
   localparam logic [7:0] CR_PATTERN_Y       = 8'h4f;
   localparam logic [7:0] CR_SYSTEM_CTRL_TWO = 8'h51;
   localparam logic [7:0] CR_MEMORY_CONTROL  = 8'h53;
   localparam logic [7:0] CR_DAC_CONTROL     = 8'h55;
   localparam logic [7:0] CR_WINDOW_CONTROL  = 8'h58;
   localparam logic [7:0] CR_WINDOW_POS_HIGH = 8'h59;
   localparam logic [7:0] CR_WINDOW_POS_LOW  = 8'h5a;
   localparam logic [7:0] CR_HORIZ_OVERFLOW  = 8'h5d;
   localparam logic [7:0] CR_VERT_OVERFLOW   = 8'h5e;
   localparam logic [7:0] CR_PIXEL_FORMAT    = 8'h67;
   localparam logic [7:0] CR_START_ADDR_HIGH = 8'h69;
   localparam logic [7:0] CR_BANK_NUMBER     = 8'h6a;

   // Sequencer register indexes.
   localparam logic [7:0] SR_PLL_UNLOCK      = 8'h08;
   localparam logic [7:0] SR_MEM_PLL_LOW     = 8'h10;
   localparam logic [7:0] SR_MEM_PLL_HIGH    = 8'h11;
   localparam logic [7:0] SR_VID_PLL_LOW     = 8'h12;
   localparam logic [7:0] SR_VID_PLL_HIGH    = 8'h13;
   localparam logic [7:0] SR_PLL_COMMAND     = 8'h15;

   // Fixed identification bytes and the bank unlock key.
   localparam logic [7:0] CHIP_ID_HIGH_VALUE  = 8'h88;
   localparam logic [7:0] CHIP_ID_LOW_VALUE   = 8'h11;
   localparam logic [7:0] CHIP_REVISION_VALUE = 8'he0;
   localparam logic [7:0] CONFIG_ONE_VALUE    = 8'h8e;
   localparam logic [7:0] CONFIG_TWO_VALUE    = 8'h2b;
   localparam logic [7:0] BANK_UNLOCK_KEY     = 8'h48;

endpackage

// ===== src/svga_extended_register_file_top.sv =====
// Extended CRTC and sequencer register file.
// The req channel carries one register access per transfer: a function code
// (CRTC write or read, sequencer write or read), an index and a write byte.
// The rsp channel returns one result per access: the read byte, change
// notifications for the display logic, and the merged high fields (bank,
// scan length, display start, line compare) as they stand after the access.
// The result of an access is registered and offered from the cycle after it
// is accepted. One access is taken per cycle while the receiver does not stall;
// the register decode and update plus the result register allow that rate.
// The result register acts as the output stage, so a new access is taken in
// the same cycle that the waiting result is transferred. When the receiver
// stalls, req_ready drops and the result holds until it is taken.
// Synchronous reset clears every register but the result data to zero and empties the result
// stage; accesses are taken from the first cycle after reset.
module svga_extended_register_file_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  svga_erf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output svga_erf_pkg::rsp_type rsp_data
);

   logic        req_accept;

   logic [7:0]  memory_config_ff, memory_config_in;
   logic [3:0]  lock_bits_ff, lock_bits_in;
   logic [7:0]  unlock_key_one_ff, unlock_key_one_in;
   logic [7:0]  unlock_key_two_ff, unlock_key_two_in;
   logic [7:0]  system_config_ff, system_config_in;
   logic [7:0]  extended_mode_ff, extended_mode_in;
   logic [7:0]  cursor_mode_ff, cursor_mode_in;
   logic [15:0] cursor_origin_x_ff, cursor_origin_x_in;
   logic [15:0] cursor_origin_y_ff, cursor_origin_y_in;
   logic [7:0]  fore_stack_ff [3];
   logic [7:0]  fore_stack_in [3];
   logic [7:0]  back_stack_ff [3];
   logic [7:0]  back_stack_in [3];
   logic [1:0]  fore_pos_ff, fore_pos_in;
   logic [1:0]  back_pos_ff, back_pos_in;
   logic [1:0]  fore_slot, back_slot;
   logic [15:0] cursor_start_ff, cursor_start_in;
   logic [7:0]  pattern_x_ff, pattern_x_in;
   logic [7:0]  pattern_y_ff, pattern_y_in;
   logic [1:0]  system_ctrl_two_ff, system_ctrl_two_in;
   logic [7:0]  memory_control_ff, memory_control_in;
   logic [7:0]  dac_control_ff, dac_control_in;
   logic [7:0]  window_control_ff, window_control_in;
   logic [15:0] window_position_ff, window_position_in;
   logic [7:0]  horiz_overflow_ff, horiz_overflow_in;
   logic [7:0]  vert_overflow_ff, vert_overflow_in;
   logic [7:0]  pixel_format_ff, pixel_format_in;
   logic [5:0]  bank_number_ff, bank_number_in;
   logic [1:0]  scan_width_high_ff, scan_width_high_in;
   logic [4:0]  start_addr_high_ff, start_addr_high_in;
   logic        compare_bit_ten_ff, compare_bit_ten_in;
   logic [7:0]  pll_unlock_ff, pll_unlock_in;
   logic [14:0] memory_pll_ff, memory_pll_in;
   logic [14:0] video_pll_ff, video_pll_in;
   logic [7:0]  pll_command_ff, pll_command_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   svga_erf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [7:0]  wr;
   logic [1:0]  new_bank_top;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign wr           = req_data.write_data;
   assign new_bank_top = wr[3:2];
   // A colour push at the end of the stack wraps to the first entry.
   assign fore_slot    = (fore_pos_ff > 2'd2) ? 2'd0 : fore_pos_ff;
   assign back_slot    = (back_pos_ff > 2'd2) ? 2'd0 : back_pos_ff;

   always_comb begin
      memory_config_in   = memory_config_ff;
      lock_bits_in       = lock_bits_ff;
      unlock_key_one_in  = unlock_key_one_ff;
      unlock_key_two_in  = unlock_key_two_ff;
      system_config_in   = system_config_ff;
      extended_mode_in   = extended_mode_ff;
      cursor_mode_in     = cursor_mode_ff;
      cursor_origin_x_in = cursor_origin_x_ff;
      cursor_origin_y_in = cursor_origin_y_ff;
      fore_stack_in      = fore_stack_ff;
      back_stack_in      = back_stack_ff;
      fore_pos_in        = fore_pos_ff;
      back_pos_in        = back_pos_ff;
      cursor_start_in    = cursor_start_ff;
      pattern_x_in       = pattern_x_ff;
      pattern_y_in       = pattern_y_ff;
      system_ctrl_two_in = system_ctrl_two_ff;
      memory_control_in  = memory_control_ff;
      dac_control_in     = dac_control_ff;
      window_control_in  = window_control_ff;
      window_position_in = window_position_ff;
      horiz_overflow_in  = horiz_overflow_ff;
      vert_overflow_in   = vert_overflow_ff;
      pixel_format_in    = pixel_format_ff;
      bank_number_in     = bank_number_ff;
      scan_width_high_in = scan_width_high_ff;
      start_addr_high_in = start_addr_high_ff;
      compare_bit_ten_in = compare_bit_ten_ff;
      pll_unlock_in      = pll_unlock_ff;
      memory_pll_in      = memory_pll_ff;
      video_pll_in       = video_pll_ff;
      pll_command_in     = pll_command_ff;

      rsp_data_in = '0;

      case (req_data.func)
         svga_erf_pkg::FUNC_CRTC_WRITE: begin
            case (req_data.index)
               svga_erf_pkg::CR_MEMORY_CONFIG: begin
                  memory_config_in         = wr;
                  rsp_data_in.mode_changed = 1'b1;
               end
               svga_erf_pkg::CR_BANK_LOCK: begin
                  if (unlock_key_one_ff == svga_erf_pkg::BANK_UNLOCK_KEY) begin
                     lock_bits_in = wr[7:4];
                     if (bank_number_ff[3:0] != wr[3:0]) begin
                        bank_number_in[3:0]      = wr[3:0];
                        rsp_data_in.bank_changed = 1'b1;
                     end
                  end
               end
               svga_erf_pkg::CR_UNLOCK_ONE:    unlock_key_one_in = wr;
               svga_erf_pkg::CR_UNLOCK_TWO:    unlock_key_two_in = wr;
               svga_erf_pkg::CR_SYSTEM_CONFIG: system_config_in  = wr;
               svga_erf_pkg::CR_EXTENDED_MODE: begin
                  // Bit 2 lives in the scan length field, not in this register.
                  extended_mode_in = {wr[7:3], 1'b0, wr[1:0]};
                  if (wr[2] != scan_width_high_ff[0]) begin
                     scan_width_high_in[0]           = wr[2];
                     rsp_data_in.scan_length_changed = 1'b1;
                  end
               end
               svga_erf_pkg::CR_CURSOR_MODE: begin
                  cursor_mode_in                  = wr;
                  rsp_data_in.cursor_mode_changed = 1'b1;
               end
               svga_erf_pkg::CR_CURSOR_X_HIGH:  cursor_origin_x_in[15:8] = wr;
               svga_erf_pkg::CR_CURSOR_X_LOW:   cursor_origin_x_in[7:0]  = wr;
               svga_erf_pkg::CR_CURSOR_Y_HIGH:  cursor_origin_y_in[15:8] = wr;
               svga_erf_pkg::CR_CURSOR_Y_LOW:   cursor_origin_y_in[7:0]  = wr;
               svga_erf_pkg::CR_FORE_COLOUR: begin
                  fore_stack_in[fore_slot] = wr;
                  fore_pos_in              = fore_slot + 2'd1;
               end
               svga_erf_pkg::CR_BACK_COLOUR: begin
                  back_stack_in[back_slot] = wr;
                  back_pos_in              = back_slot + 2'd1;
               end
               svga_erf_pkg::CR_CURSOR_ADDR_HI: cursor_start_in[15:8] = wr;
               svga_erf_pkg::CR_CURSOR_ADDR_LO: cursor_start_in[7:0]  = wr;
               svga_erf_pkg::CR_PATTERN_X:      pattern_x_in          = wr;
               svga_erf_pkg::CR_PATTERN_Y:      pattern_y_in          = wr;
               svga_erf_pkg::CR_SYSTEM_CTRL_TWO: begin
                  system_ctrl_two_in      = wr[7:6];
                  start_addr_high_in[1:0] = wr[1:0];
                  // The bank is left alone only when the whole new value is zero.
                  if (bank_number_ff[3:0] != 4'd0 || new_bank_top != 2'd0) begin
                     bank_number_in[5:4]      = new_bank_top;
                     rsp_data_in.bank_changed = 1'b1;
                  end
                  if (wr[5:4] != scan_width_high_ff) begin
                     scan_width_high_in              = wr[5:4];
                     rsp_data_in.scan_length_changed = 1'b1;
                  end
               end
               svga_erf_pkg::CR_MEMORY_CONTROL: memory_control_in = wr;
               svga_erf_pkg::CR_DAC_CONTROL:    dac_control_in    = wr;
               svga_erf_pkg::CR_WINDOW_CONTROL: window_control_in = wr;
               svga_erf_pkg::CR_WINDOW_POS_HIGH: begin
                  if (window_position_ff[15:8] != wr) begin
                     window_position_in[15:8] = wr;
                     rsp_data_in.window_moved = 1'b1;
                  end
               end
               svga_erf_pkg::CR_WINDOW_POS_LOW: begin
                  if (window_position_ff[7:0] != wr) begin
                     window_position_in[7:0]  = wr;
                     rsp_data_in.window_moved = 1'b1;
                  end
               end
               svga_erf_pkg::CR_HORIZ_OVERFLOW: begin
                  if ((wr & horiz_overflow_ff) != 8'd3) begin
                     rsp_data_in.timing_changed = 1'b1;
                  end
                  horiz_overflow_in = wr;
               end
               svga_erf_pkg::CR_VERT_OVERFLOW: begin
                  compare_bit_ten_in = wr[6];
                  if (wr[1:0] != vert_overflow_ff[1:0]) begin
                     rsp_data_in.timing_changed = 1'b1;
                  end
                  vert_overflow_in = wr;
               end
               svga_erf_pkg::CR_PIXEL_FORMAT: begin
                  pixel_format_in          = wr;
                  rsp_data_in.mode_changed = 1'b1;
               end
               svga_erf_pkg::CR_START_ADDR_HIGH: start_addr_high_in = wr[4:0];
               svga_erf_pkg::CR_BANK_NUMBER: begin
                  bank_number_in           = wr[5:0];
                  rsp_data_in.bank_changed = 1'b1;
               end
               default: rsp_data_in.unknown_index = 1'b1;
            endcase
         end
         svga_erf_pkg::FUNC_CRTC_READ: begin
            case (req_data.index)
               svga_erf_pkg::CR_CHIP_ID_HIGH:
                  rsp_data_in.read_data = svga_erf_pkg::CHIP_ID_HIGH_VALUE;
               svga_erf_pkg::CR_CHIP_ID_LOW:
                  rsp_data_in.read_data = svga_erf_pkg::CHIP_ID_LOW_VALUE;
               svga_erf_pkg::CR_CHIP_REVISION:
                  rsp_data_in.read_data = svga_erf_pkg::CHIP_REVISION_VALUE;
               svga_erf_pkg::CR_MEMORY_CONFIG: rsp_data_in.read_data = memory_config_ff;
               svga_erf_pkg::CR_BANK_LOCK:
                  rsp_data_in.read_data = {lock_bits_ff, bank_number_ff[3:0]};
               svga_erf_pkg::CR_CONFIG_ONE:
                  rsp_data_in.read_data = svga_erf_pkg::CONFIG_ONE_VALUE;
               svga_erf_pkg::CR_CONFIG_TWO:
                  rsp_data_in.read_data = svga_erf_pkg::CONFIG_TWO_VALUE;
               svga_erf_pkg::CR_UNLOCK_ONE:    rsp_data_in.read_data = unlock_key_one_ff;
               svga_erf_pkg::CR_UNLOCK_TWO:    rsp_data_in.read_data = unlock_key_two_ff;
               svga_erf_pkg::CR_SYSTEM_CONFIG: rsp_data_in.read_data = system_config_ff;
               svga_erf_pkg::CR_EXTENDED_MODE:
                  rsp_data_in.read_data = extended_mode_ff
                                          | {5'd0, scan_width_high_ff[0], 2'd0};
               svga_erf_pkg::CR_CURSOR_MODE: begin
                  // Reading the cursor mode rewinds both colour stacks.
                  fore_pos_in           = 2'd0;
                  back_pos_in           = 2'd0;
                  rsp_data_in.read_data = cursor_mode_ff;
               end
               svga_erf_pkg::CR_SYSTEM_CTRL_TWO:
                  rsp_data_in.read_data = {system_ctrl_two_ff, scan_width_high_ff,
                                           bank_number_ff[5:4], start_addr_high_ff[1:0]};
               svga_erf_pkg::CR_MEMORY_CONTROL: rsp_data_in.read_data = memory_control_ff;
               svga_erf_pkg::CR_DAC_CONTROL:    rsp_data_in.read_data = dac_control_ff;
               svga_erf_pkg::CR_WINDOW_CONTROL: rsp_data_in.read_data = window_control_ff;
               svga_erf_pkg::CR_WINDOW_POS_HIGH:
                  rsp_data_in.read_data = window_position_ff[15:8];
               svga_erf_pkg::CR_WINDOW_POS_LOW:
                  rsp_data_in.read_data = window_position_ff[7:0];
               svga_erf_pkg::CR_HORIZ_OVERFLOW: rsp_data_in.read_data = horiz_overflow_ff;
               svga_erf_pkg::CR_VERT_OVERFLOW:  rsp_data_in.read_data = vert_overflow_ff;
               svga_erf_pkg::CR_PIXEL_FORMAT:   rsp_data_in.read_data = pixel_format_ff;
               svga_erf_pkg::CR_START_ADDR_HIGH:
                  rsp_data_in.read_data = {3'd0, start_addr_high_ff};
               svga_erf_pkg::CR_BANK_NUMBER:
                  rsp_data_in.read_data = {2'd0, bank_number_ff};
               default: rsp_data_in.read_data = 8'd0;
            endcase
         end
         svga_erf_pkg::FUNC_SEQ_WRITE: begin
            case (req_data.index)
               svga_erf_pkg::SR_PLL_UNLOCK:   pll_unlock_in       = wr;
               svga_erf_pkg::SR_MEM_PLL_LOW:  memory_pll_in[7:0]  = wr;
               svga_erf_pkg::SR_MEM_PLL_HIGH: memory_pll_in[14:8] = wr[6:0];
               svga_erf_pkg::SR_VID_PLL_LOW:  video_pll_in[7:0]   = wr;
               svga_erf_pkg::SR_VID_PLL_HIGH: video_pll_in[14:8]  = wr[6:0];
               svga_erf_pkg::SR_PLL_COMMAND: begin
                  pll_command_in             = wr;
                  rsp_data_in.timing_changed = 1'b1;
               end
               default: rsp_data_in.unknown_index = 1'b1;
            endcase
         end
         default: begin
            case (req_data.index)
               svga_erf_pkg::SR_PLL_UNLOCK:   rsp_data_in.read_data = pll_unlock_ff;
               svga_erf_pkg::SR_MEM_PLL_LOW:  rsp_data_in.read_data = memory_pll_ff[7:0];
               svga_erf_pkg::SR_MEM_PLL_HIGH:
                  rsp_data_in.read_data = {1'b0, memory_pll_ff[14:8]};
               svga_erf_pkg::SR_VID_PLL_LOW:  rsp_data_in.read_data = video_pll_ff[7:0];
               svga_erf_pkg::SR_VID_PLL_HIGH:
                  rsp_data_in.read_data = {1'b0, video_pll_ff[14:8]};
               svga_erf_pkg::SR_PLL_COMMAND:  rsp_data_in.read_data = pll_command_ff;
               default: rsp_data_in.unknown_index = 1'b1;
            endcase
         end
      endcase

      rsp_data_in.bank_value         = bank_number_in;
      rsp_data_in.scan_length_high   = scan_width_high_in;
      rsp_data_in.display_start_high = start_addr_high_in;
      rsp_data_in.line_compare_high  = compare_bit_ten_in;

      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         memory_config_ff   <= '0;
         lock_bits_ff       <= '0;
         unlock_key_one_ff  <= '0;
         unlock_key_two_ff  <= '0;
         system_config_ff   <= '0;
         extended_mode_ff   <= '0;
         cursor_mode_ff     <= '0;
         cursor_origin_x_ff <= '0;
         cursor_origin_y_ff <= '0;
         fore_stack_ff      <= '{default: '0};
         back_stack_ff      <= '{default: '0};
         fore_pos_ff        <= '0;
         back_pos_ff        <= '0;
         cursor_start_ff    <= '0;
         pattern_x_ff       <= '0;
         pattern_y_ff       <= '0;
         system_ctrl_two_ff <= '0;
         memory_control_ff  <= '0;
         dac_control_ff     <= '0;
         window_control_ff  <= '0;
         window_position_ff <= '0;
         horiz_overflow_ff  <= '0;
         vert_overflow_ff   <= '0;
         pixel_format_ff    <= '0;
         bank_number_ff     <= '0;
         scan_width_high_ff <= '0;
         start_addr_high_ff <= '0;
         compare_bit_ten_ff <= '0;
         pll_unlock_ff      <= '0;
         memory_pll_ff      <= '0;
         video_pll_ff       <= '0;
         pll_command_ff     <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (req_accept) begin
            memory_config_ff   <= memory_config_in;
            lock_bits_ff       <= lock_bits_in;
            unlock_key_one_ff  <= unlock_key_one_in;
            unlock_key_two_ff  <= unlock_key_two_in;
            system_config_ff   <= system_config_in;
            extended_mode_ff   <= extended_mode_in;
            cursor_mode_ff     <= cursor_mode_in;
            cursor_origin_x_ff <= cursor_origin_x_in;
            cursor_origin_y_ff <= cursor_origin_y_in;
            fore_stack_ff      <= fore_stack_in;
            back_stack_ff      <= back_stack_in;
            fore_pos_ff        <= fore_pos_in;
            back_pos_ff        <= back_pos_in;
            cursor_start_ff    <= cursor_start_in;
            pattern_x_ff       <= pattern_x_in;
            pattern_y_ff       <= pattern_y_in;
            system_ctrl_two_ff <= system_ctrl_two_in;
            memory_control_ff  <= memory_control_in;
            dac_control_ff     <= dac_control_in;
            window_control_ff  <= window_control_in;
            window_position_ff <= window_position_in;
            horiz_overflow_ff  <= horiz_overflow_in;
            vert_overflow_ff   <= vert_overflow_in;
            pixel_format_ff    <= pixel_format_in;
            bank_number_ff     <= bank_number_in;
            scan_width_high_ff <= scan_width_high_in;
            start_addr_high_ff <= start_addr_high_in;
            compare_bit_ten_ff <= compare_bit_ten_in;
            pll_unlock_ff      <= pll_unlock_in;
            memory_pll_ff      <= memory_pll_in;
            video_pll_ff       <= video_pll_in;
            pll_command_ff     <= pll_command_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== src/svga_erf_checker.sv =====
`include "assert_macros.svh"

module svga_erf_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input svga_erf_pkg::req_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input svga_erf_pkg::rsp_type rsp_data
);

   logic write_accept;

   assign write_accept = req_valid && req_ready
                         && (req_data.func == svga_erf_pkg::FUNC_CRTC_WRITE
                             || req_data.func == svga_erf_pkg::FUNC_SEQ_WRITE);

   `ASSERT_CLK_ALWAYS(a_reset_empties, reset |=> !rsp_valid)

   `ASSERT_CLK(a_accept_gives_result, (req_valid && req_ready) |=> rsp_valid)

   `ASSERT_CLK(a_stall_holds, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))

   // Only a waiting result that is not taken may hold back the next access.
   `ASSERT_CLK(a_ready_only_on_stall, !req_ready |-> (rsp_valid && !rsp_ready))

   // A write returns no read data.
   `ASSERT_CLK(a_write_no_data, write_accept |=> (rsp_data.read_data == 8'd0))

endmodule

bind svga_extended_register_file_top svga_erf_checker u_svga_erf_checker (.*);

// ===== tb/tb_svga_extended_register_file_top.sv =====
`timescale 1ns / 100ps

module tb_svga_extended_register_file_top;

   localparam int unsigned CYCLE_LIMIT = 200000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   svga_erf_pkg::req_type req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   svga_erf_pkg::rsp_type rsp_data;

   int unsigned           cycle_count = 0;
   int unsigned           error_count = 0;
   bit                    no_gaps = 1'b0;
   svga_erf_pkg::rsp_type expected_results [$];

   logic [7:0] crtc_indexes [33] = '{
      svga_erf_pkg::CR_CHIP_ID_HIGH, svga_erf_pkg::CR_CHIP_ID_LOW,
      svga_erf_pkg::CR_CHIP_REVISION, svga_erf_pkg::CR_MEMORY_CONFIG,
      svga_erf_pkg::CR_BANK_LOCK, svga_erf_pkg::CR_CONFIG_ONE, svga_erf_pkg::CR_CONFIG_TWO,
      svga_erf_pkg::CR_UNLOCK_ONE, svga_erf_pkg::CR_UNLOCK_TWO,
      svga_erf_pkg::CR_SYSTEM_CONFIG, svga_erf_pkg::CR_EXTENDED_MODE,
      svga_erf_pkg::CR_CURSOR_MODE, svga_erf_pkg::CR_CURSOR_X_HIGH,
      svga_erf_pkg::CR_CURSOR_X_LOW, svga_erf_pkg::CR_CURSOR_Y_HIGH,
      svga_erf_pkg::CR_CURSOR_Y_LOW, svga_erf_pkg::CR_FORE_COLOUR,
      svga_erf_pkg::CR_BACK_COLOUR, svga_erf_pkg::CR_CURSOR_ADDR_HI,
      svga_erf_pkg::CR_CURSOR_ADDR_LO, svga_erf_pkg::CR_PATTERN_X, svga_erf_pkg::CR_PATTERN_Y,
      svga_erf_pkg::CR_SYSTEM_CTRL_TWO, svga_erf_pkg::CR_MEMORY_CONTROL,
      svga_erf_pkg::CR_DAC_CONTROL, svga_erf_pkg::CR_WINDOW_CONTROL,
      svga_erf_pkg::CR_WINDOW_POS_HIGH, svga_erf_pkg::CR_WINDOW_POS_LOW,
      svga_erf_pkg::CR_HORIZ_OVERFLOW, svga_erf_pkg::CR_VERT_OVERFLOW,
      svga_erf_pkg::CR_PIXEL_FORMAT, svga_erf_pkg::CR_START_ADDR_HIGH,
      svga_erf_pkg::CR_BANK_NUMBER};
   logic [7:0] seq_indexes [6] = '{
      svga_erf_pkg::SR_PLL_UNLOCK, svga_erf_pkg::SR_MEM_PLL_LOW,
      svga_erf_pkg::SR_MEM_PLL_HIGH, svga_erf_pkg::SR_VID_PLL_LOW,
      svga_erf_pkg::SR_VID_PLL_HIGH, svga_erf_pkg::SR_PLL_COMMAND};

   // Register image kept alongside the block. Cursor origin, colour stacks, cursor
   // start address and pattern offsets never reach the result, so only their
   // writes are decoded.
   logic [7:0]  mem_cfg, unlock_one, unlock_two, sys_cfg, ext_mode, curs_mode;
   logic [3:0]  lock_nib;
   logic [1:0]  sys_ctl2;
   logic [7:0]  mem_ctl, dac_ctl, win_ctl, h_ovf, v_ovf, pix_fmt, pll_key, pll_cmd;
   logic [15:0] win_pos;
   logic [5:0]  bank;
   logic [1:0]  scan_hi;
   logic [4:0]  start_hi;
   logic        lc_bit10;
   logic [14:0] mclk_word, vclk_word;

   svga_extended_register_file_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic svga_erf_pkg::rsp_type apply_register_access(
      svga_erf_pkg::req_type acc);
      svga_erf_pkg::rsp_type r;
      logic [7:0]            v;
      v = acc.write_data;
      r = '0;
      case (acc.func)
         svga_erf_pkg::FUNC_CRTC_WRITE: begin
            case (acc.index)
               svga_erf_pkg::CR_MEMORY_CONFIG: begin
                  mem_cfg = v;
                  r.mode_changed = 1'b1;
               end
               svga_erf_pkg::CR_BANK_LOCK: begin
                  if (unlock_one == svga_erf_pkg::BANK_UNLOCK_KEY) begin
                     lock_nib = v[7:4];
                     if (bank[3:0] != v[3:0]) begin
                        bank[3:0] = v[3:0];
                        r.bank_changed = 1'b1;
                     end
                  end
               end
               svga_erf_pkg::CR_UNLOCK_ONE: unlock_one = v;
               svga_erf_pkg::CR_UNLOCK_TWO: unlock_two = v;
               svga_erf_pkg::CR_SYSTEM_CONFIG: sys_cfg = v;
               svga_erf_pkg::CR_EXTENDED_MODE: begin
                  ext_mode = v & 8'hfb;
                  if (v[2] != scan_hi[0]) begin
                     scan_hi[0] = v[2];
                     r.scan_length_changed = 1'b1;
                  end
               end
               svga_erf_pkg::CR_CURSOR_MODE: begin
                  curs_mode = v;
                  r.cursor_mode_changed = 1'b1;
               end
               svga_erf_pkg::CR_CURSOR_X_HIGH, svga_erf_pkg::CR_CURSOR_X_LOW,
               svga_erf_pkg::CR_CURSOR_Y_HIGH, svga_erf_pkg::CR_CURSOR_Y_LOW,
               svga_erf_pkg::CR_FORE_COLOUR, svga_erf_pkg::CR_BACK_COLOUR,
               svga_erf_pkg::CR_CURSOR_ADDR_HI, svga_erf_pkg::CR_CURSOR_ADDR_LO,
               svga_erf_pkg::CR_PATTERN_X, svga_erf_pkg::CR_PATTERN_Y: ;
               svga_erf_pkg::CR_SYSTEM_CTRL_TWO: begin
                  sys_ctl2 = v[7:6];
                  start_hi[1:0] = v[1:0];
                  // The upper bank bits stay put only when the whole new bank value would be zero.
                  if (bank[3:0] != 4'd0 || v[3:2] != 2'd0) begin
                     bank[5:4] = v[3:2];
                     r.bank_changed = 1'b1;
                  end
                  if (v[5:4] != scan_hi) begin
                     scan_hi = v[5:4];
                     r.scan_length_changed = 1'b1;
                  end
               end
               svga_erf_pkg::CR_MEMORY_CONTROL: mem_ctl = v;
               svga_erf_pkg::CR_DAC_CONTROL: dac_ctl = v;
               svga_erf_pkg::CR_WINDOW_CONTROL: win_ctl = v;
               svga_erf_pkg::CR_WINDOW_POS_HIGH: begin
                  if (win_pos[15:8] != v) begin
                     win_pos[15:8] = v;
                     r.window_moved = 1'b1;
                  end
               end
               svga_erf_pkg::CR_WINDOW_POS_LOW: begin
                  if (win_pos[7:0] != v) begin
                     win_pos[7:0] = v;
                     r.window_moved = 1'b1;
                  end
               end
               svga_erf_pkg::CR_HORIZ_OVERFLOW: begin
                  if ((v & h_ovf) != 8'h03) r.timing_changed = 1'b1;
                  h_ovf = v;
               end
               svga_erf_pkg::CR_VERT_OVERFLOW: begin
                  lc_bit10 = v[6];
                  if (v[1:0] != v_ovf[1:0]) r.timing_changed = 1'b1;
                  v_ovf = v;
               end
               svga_erf_pkg::CR_PIXEL_FORMAT: begin
                  pix_fmt = v;
                  r.mode_changed = 1'b1;
               end
               svga_erf_pkg::CR_START_ADDR_HIGH: start_hi = v[4:0];
               svga_erf_pkg::CR_BANK_NUMBER: begin
                  bank = v[5:0];
                  r.bank_changed = 1'b1;
               end
               default: r.unknown_index = 1'b1;
            endcase
         end
         svga_erf_pkg::FUNC_CRTC_READ: begin
            case (acc.index)
               svga_erf_pkg::CR_CHIP_ID_HIGH: r.read_data = svga_erf_pkg::CHIP_ID_HIGH_VALUE;
               svga_erf_pkg::CR_CHIP_ID_LOW: r.read_data = svga_erf_pkg::CHIP_ID_LOW_VALUE;
               svga_erf_pkg::CR_CHIP_REVISION:
                  r.read_data = svga_erf_pkg::CHIP_REVISION_VALUE;
               svga_erf_pkg::CR_MEMORY_CONFIG: r.read_data = mem_cfg;
               svga_erf_pkg::CR_BANK_LOCK: r.read_data = {lock_nib, bank[3:0]};
               svga_erf_pkg::CR_CONFIG_ONE: r.read_data = svga_erf_pkg::CONFIG_ONE_VALUE;
               svga_erf_pkg::CR_CONFIG_TWO: r.read_data = svga_erf_pkg::CONFIG_TWO_VALUE;
               svga_erf_pkg::CR_UNLOCK_ONE: r.read_data = unlock_one;
               svga_erf_pkg::CR_UNLOCK_TWO: r.read_data = unlock_two;
               svga_erf_pkg::CR_SYSTEM_CONFIG: r.read_data = sys_cfg;
               svga_erf_pkg::CR_EXTENDED_MODE:
                  r.read_data = ext_mode | {5'd0, scan_hi[0], 2'd0};
               svga_erf_pkg::CR_CURSOR_MODE: r.read_data = curs_mode;
               svga_erf_pkg::CR_SYSTEM_CTRL_TWO:
                  r.read_data = {sys_ctl2, scan_hi, bank[5:4], start_hi[1:0]};
               svga_erf_pkg::CR_MEMORY_CONTROL: r.read_data = mem_ctl;
               svga_erf_pkg::CR_DAC_CONTROL: r.read_data = dac_ctl;
               svga_erf_pkg::CR_WINDOW_CONTROL: r.read_data = win_ctl;
               svga_erf_pkg::CR_WINDOW_POS_HIGH: r.read_data = win_pos[15:8];
               svga_erf_pkg::CR_WINDOW_POS_LOW: r.read_data = win_pos[7:0];
               svga_erf_pkg::CR_HORIZ_OVERFLOW: r.read_data = h_ovf;
               svga_erf_pkg::CR_VERT_OVERFLOW: r.read_data = v_ovf;
               svga_erf_pkg::CR_PIXEL_FORMAT: r.read_data = pix_fmt;
               svga_erf_pkg::CR_START_ADDR_HIGH: r.read_data = {3'd0, start_hi};
               svga_erf_pkg::CR_BANK_NUMBER: r.read_data = {2'd0, bank};
               default: r.read_data = 8'd0;
            endcase
         end
         svga_erf_pkg::FUNC_SEQ_WRITE: begin
            case (acc.index)
               svga_erf_pkg::SR_PLL_UNLOCK: pll_key = v;
               svga_erf_pkg::SR_MEM_PLL_LOW: mclk_word[7:0] = v;
               svga_erf_pkg::SR_MEM_PLL_HIGH: mclk_word[14:8] = v[6:0];
               svga_erf_pkg::SR_VID_PLL_LOW: vclk_word[7:0] = v;
               svga_erf_pkg::SR_VID_PLL_HIGH: vclk_word[14:8] = v[6:0];
               svga_erf_pkg::SR_PLL_COMMAND: begin
                  pll_cmd = v;
                  r.timing_changed = 1'b1;
               end
               default: r.unknown_index = 1'b1;
            endcase
         end
         default: begin
            case (acc.index)
               svga_erf_pkg::SR_PLL_UNLOCK: r.read_data = pll_key;
               svga_erf_pkg::SR_MEM_PLL_LOW: r.read_data = mclk_word[7:0];
               svga_erf_pkg::SR_MEM_PLL_HIGH: r.read_data = {1'b0, mclk_word[14:8]};
               svga_erf_pkg::SR_VID_PLL_LOW: r.read_data = vclk_word[7:0];
               svga_erf_pkg::SR_VID_PLL_HIGH: r.read_data = {1'b0, vclk_word[14:8]};
               svga_erf_pkg::SR_PLL_COMMAND: r.read_data = pll_cmd;
               default: r.unknown_index = 1'b1;
            endcase
         end
      endcase
      r.bank_value = bank;
      r.scan_length_high = scan_hi;
      r.display_start_high = start_hi;
      r.line_compare_high = lc_bit10;
      return r;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
         error_count++;
      end
   endtask

   // Requests are recorded after results so that a result appearing in the same
   // cycle as its own request is still caught as unexpected.
   always @(posedge clock) begin
      svga_erf_pkg::rsp_type want;
      if (reset) begin
         expected_results.delete();
         mem_cfg = '0; unlock_one = '0; unlock_two = '0; sys_cfg = '0;
         ext_mode = '0; curs_mode = '0; lock_nib = '0; sys_ctl2 = '0;
         mem_ctl = '0; dac_ctl = '0; win_ctl = '0; h_ovf = '0; v_ovf = '0;
         pix_fmt = '0; pll_key = '0; pll_cmd = '0; win_pos = '0; bank = '0;
         scan_hi = '0; start_hi = '0; lc_bit10 = '0; mclk_word = '0; vclk_word = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with no access outstanding");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("read_data", want.read_data, rsp_data.read_data);
               check_field("mode_changed", 8'(want.mode_changed),
                           8'(rsp_data.mode_changed));
               check_field("bank_changed", 8'(want.bank_changed),
                           8'(rsp_data.bank_changed));
               check_field("scan_length_changed", 8'(want.scan_length_changed),
                           8'(rsp_data.scan_length_changed));
               check_field("window_moved", 8'(want.window_moved),
                           8'(rsp_data.window_moved));
               check_field("timing_changed", 8'(want.timing_changed),
                           8'(rsp_data.timing_changed));
               check_field("cursor_mode_changed", 8'(want.cursor_mode_changed),
                           8'(rsp_data.cursor_mode_changed));
               check_field("bank_value", 8'(want.bank_value), 8'(rsp_data.bank_value));
               check_field("scan_length_high", 8'(want.scan_length_high),
                           8'(rsp_data.scan_length_high));
               check_field("display_start_high", 8'(want.display_start_high),
                           8'(rsp_data.display_start_high));
               check_field("line_compare_high", 8'(want.line_compare_high),
                           8'(rsp_data.line_compare_high));
               check_field("unknown_index", 8'(want.unknown_index),
                           8'(rsp_data.unknown_index));
            end
         end
         if (req_valid && req_ready) expected_results.push_back(apply_register_access(req_data));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // Receiver: bursts of ready, at times separated by stalls of random length; none while no_gaps is set.
   initial begin
      int unsigned run;
      int unsigned hold;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         run = no_gaps ? 64 : $urandom_range(1, 12);
         hold = no_gaps ? 0 : pick_gap();
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // Valid is left high on return; the next call or a drain decides whether it drops.
   task automatic issue_access(svga_erf_pkg::func_type f, logic [7:0] idx, logic [7:0] data);
      int unsigned           gap;
      svga_erf_pkg::req_type item;
      gap = no_gaps ? 0 : pick_gap();
      item.func = f;
      item.index = idx;
      item.write_data = data;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_identification_bytes();
      issue_access(svga_erf_pkg::FUNC_CRTC_READ, svga_erf_pkg::CR_CHIP_ID_HIGH, 8'h00);
      issue_access(svga_erf_pkg::FUNC_CRTC_READ, svga_erf_pkg::CR_CONFIG_TWO, 8'hff);
   endtask

   task automatic test_bank_fields();
      // Locked write first, then the same register once the key is in place.
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_BANK_LOCK, 8'h0f);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_UNLOCK_ONE,
                   svga_erf_pkg::BANK_UNLOCK_KEY);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_BANK_LOCK, 8'ha5);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_BANK_LOCK, 8'h55);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_BANK_NUMBER, 8'h00);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_SYSTEM_CTRL_TWO, 8'h00);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_SYSTEM_CTRL_TWO, 8'hff);
      issue_access(svga_erf_pkg::FUNC_CRTC_READ, svga_erf_pkg::CR_SYSTEM_CTRL_TWO, 8'h00);
   endtask

   task automatic test_overflow_timing();
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_HORIZ_OVERFLOW, 8'h03);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_HORIZ_OVERFLOW, 8'hff);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_VERT_OVERFLOW, 8'h41);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_VERT_OVERFLOW, 8'h40);
   endtask

   task automatic test_cursor_registers();
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_CURSOR_MODE, 8'hff);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_FORE_COLOUR, 8'h12);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_CURSOR_ADDR_HI, 8'hff);
      issue_access(svga_erf_pkg::FUNC_CRTC_READ, svga_erf_pkg::CR_CURSOR_MODE, 8'h00);
   endtask

   task automatic test_sequencer_plls();
      issue_access(svga_erf_pkg::FUNC_SEQ_WRITE, svga_erf_pkg::SR_MEM_PLL_HIGH, 8'hff);
      issue_access(svga_erf_pkg::FUNC_SEQ_READ, svga_erf_pkg::SR_MEM_PLL_HIGH, 8'h00);
      issue_access(svga_erf_pkg::FUNC_SEQ_WRITE, svga_erf_pkg::SR_PLL_COMMAND, 8'h00);
      issue_access(svga_erf_pkg::FUNC_SEQ_READ, 8'hff, 8'hff);
   endtask

   task automatic test_unknown_indexes();
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, 8'hff, 8'hff);
      issue_access(svga_erf_pkg::FUNC_CRTC_READ, 8'h00, 8'h00);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_WINDOW_POS_HIGH, 8'hff);
      issue_access(svga_erf_pkg::FUNC_CRTC_WRITE, svga_erf_pkg::CR_WINDOW_POS_HIGH, 8'hff);
   endtask

   task automatic test_random_accesses(int unsigned count);
      svga_erf_pkg::func_type f;
      logic [7:0]             idx;
      logic [7:0]             data;
      repeat (count) begin
         f = svga_erf_pkg::func_type'($urandom_range(0, 3));
         if ($urandom_range(0, 4) == 0) begin
            idx = 8'($urandom_range(0, 255));
         end else if (f == svga_erf_pkg::FUNC_CRTC_WRITE
                      || f == svga_erf_pkg::FUNC_CRTC_READ) begin
            idx = crtc_indexes[$urandom_range(0, 32)];
         end else begin
            idx = seq_indexes[$urandom_range(0, 5)];
         end
         data = 8'($urandom_range(0, 255));
         // Keep the bank lock open about half the time and hit the quiet overflow case.
         if (f == svga_erf_pkg::FUNC_CRTC_WRITE && idx == svga_erf_pkg::CR_UNLOCK_ONE
             && $urandom_range(0, 1) == 1)
            data = svga_erf_pkg::BANK_UNLOCK_KEY;
         if (f == svga_erf_pkg::FUNC_CRTC_WRITE && idx == svga_erf_pkg::CR_HORIZ_OVERFLOW
             && $urandom_range(0, 1) == 1)
            data[1:0] = 2'b11;
         issue_access(f, idx, data);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_identification_bytes();
      test_bank_fields();
      test_overflow_timing();
      test_cursor_registers();
      test_sequencer_plls();
      test_unknown_indexes();
      wait_for_results();
      test_random_accesses(150);
      wait_for_results();
      no_gaps = 1'b1;
      test_random_accesses(100);
      no_gaps = 1'b0;
      test_random_accesses(150);
      wait_for_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/svga_erf_pkg.sv
src/svga_extended_register_file_top.sv
src/svga_erf_checker.sv
tb/tb_svga_extended_register_file_top.sv
